// ----- sv/pva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants
// Item format, sequencer states and CORDIC constants of the population vector
// average block.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam logic [15:0] OrientTurn  = 16'd46080;
  localparam logic [10:0] RecipDiv45  = 11'd1456;
  localparam logic [6:0]  Div45       = 7'd45;
  localparam int          FracCount   = 45;
  localparam int          MaxStages   = 24;
  localparam int          FifoDepth   = 4;

  localparam logic signed [33:0] GainQ30     = 34'sd652032874;
  localparam logic signed [32:0] TurnQuarter = 33'sd1073741824;
  localparam logic signed [32:0] TurnHalf    = 33'sd2147483648;
  localparam logic signed [33:0] TurnHalfW   = 34'sd2147483648;
  localparam logic signed [39:0] AngleMax    = 40'sd23040;
  localparam logic [14:0]        GainHi      = 15'd19898;
  localparam logic [14:0]        GainLo      = 15'd15210;
  localparam logic [36:0]        MagMax      = 37'h0_7FFF_FFFF;

  typedef struct packed {
    logic signed [15:0] activation;
    logic signed [31:0] angle;
    logic               negate;
    logic               last;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT,
    S_MUL,
    S_ACC,
    S_VINIT,
    S_VEC,
    S_ANG,
    S_MAG1,
    S_MAG2,
    S_MAG3,
    S_OUT
  } state_e;

  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/pva_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_front: request intake
// Reduce the orientation, convert it to a binary angle folded into +-90
// degrees, and hand the item to the queue.
// ----------------------------------------------------------------------------
module pva_front
  import pva_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] activation_i,
  input  logic [15:0] orientation_i,
  input  logic        last_i,
  output logic        push_o,
  input  logic        push_ready_i,
  output item_t       item_o
);

  logic               st_v_q, st_v_d;
  logic signed [15:0] act_q;
  logic [15:0]        orient_q;
  logic [9:0]         quot_q;
  logic               last_q;
  logic [15:0]        orient_red;
  logic [26:0]        quot_prod;
  logic [15:0]        q45;
  logic [6:0]         rem0;
  logic [9:0]         quot;
  logic [5:0]         rem;
  logic [31:0]        pangle;
  logic signed [32:0] zw;
  logic [21:0]        frac_tab [FracCount];

  for (genvar g = 0; g < FracCount; g++) begin : g_frac
    localparam logic [21:0] Frac = 22'((64'(g) * 64'd4194304 + 64'd22) / 64'd45);
    assign frac_tab[g] = Frac;
  end

  assign ready_o = !st_v_q || push_ready_i;
  assign push_o  = st_v_q;

  always_comb begin
    orient_red = (orientation_i >= OrientTurn) ? orientation_i - OrientTurn : orientation_i;
    quot_prod  = 27'(orient_red) * 27'(RecipDiv45);
    st_v_d     = ready_o ? valid_i : st_v_q;
  end

  always_comb begin
    q45  = 16'(quot_q) * 16'(Div45);
    rem0 = 7'(orient_q - q45);
    if (rem0 >= Div45) begin
      quot = quot_q + 10'd1;
      rem  = 6'(rem0 - Div45);
    end else begin
      quot = quot_q;
      rem  = rem0[5:0];
    end
    pangle = {quot, 22'd0} + 32'(frac_tab[rem]);
    zw     = 33'(signed'(pangle));
    item_o.activation = act_q;
    item_o.last       = last_q;
    if (zw > TurnQuarter) begin
      item_o.angle  = 32'(zw - TurnHalf);
      item_o.negate = 1'b1;
    end else if (zw < -TurnQuarter) begin
      item_o.angle  = 32'(zw + TurnHalf);
      item_o.negate = 1'b1;
    end else begin
      item_o.angle  = 32'(zw);
      item_o.negate = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
    end else begin
      st_v_q <= st_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      act_q    <= signed'(activation_i);
      orient_q <= orient_red;
      quot_q   <= quot_prod[25:16];
      last_q   <= last_i;
    end
  end

endmodule

// ----- sv/pva_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_fifo: item queue
// Short queue between intake and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module pva_fifo
  import pva_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  push_ready_o,
  input  item_t item_i,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output item_t item_o
);

  localparam int PtrW = $clog2(FifoDepth);

  item_t            mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != (PtrW+1)'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign item_o       = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- sv/pva_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_back: arithmetic sequencer
// Iterative CORDIC rotation, multiply-accumulate, CORDIC vectoring on the
// last link and result scaling into the output register.
// ----------------------------------------------------------------------------
module pva_back
  import pva_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_i,
  input  logic        pop_valid_i,
  output logic        pop_o,
  input  item_t       item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_o,
  output logic        sat_o
);

  localparam int Stages = (CORDIC_STAGES < MaxStages) ? CORDIC_STAGES : MaxStages;
  localparam int CntW   = $clog2(Stages);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic signed [15:0]  act_q, act_d;
  logic                neg_q, neg_d, last_q, last_d;
  logic signed [33:0]  rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic signed [33:0]  px_q, px_d, py_q, py_d;
  logic [47:0]         xsum_q, xsum_d, ysum_q, ysum_d;
  logic signed [50:0]  vx_q, vx_d, vy_q, vy_d;
  logic signed [33:0]  vz_q, vz_d;
  logic [39:0]         a1_q, a1_d, b1_q, b1_d;
  logic [38:0]         a2_q, a2_d, b2_q, b2_d;
  logic [64:0]         hs_q, hs_d;
  logic [49:0]         ls_q, ls_d;
  logic signed [31:0]  res_q, res_d;
  logic                sat_q, sat_d;
  logic                ov_q, ov_d;
  logic                rot_done;
  logic [29:0]         atan_v;
  logic signed [17:0]  cs, sn;
  logic signed [47:0]  xs, ys;
  logic signed [39:0]  ang_w, ang_s;
  logic [48:0]         tmag;
  logic [65:0]         msum;
  logic [36:0]         mval;
  logic [63:0]         lo_full;

  assign rot_done    = cnt_q == CntW'(Stages - 1);
  assign atan_v      = atan_lut(5'(cnt_q));
  assign out_valid_o = ov_q;
  assign result_o    = res_q;
  assign sat_o       = sat_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (pop_valid_i) state_d = S_ROT;
      S_ROT:   if (rot_done) state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = last_q ? S_VINIT : S_IDLE;
      S_VINIT: begin
        if (ov_q) state_d = S_VINIT;
        else if ((xs == '0 && ys == '0) || (!mode_i && ys == '0)) state_d = S_OUT;
        else state_d = S_VEC;
      end
      S_VEC:   if (rot_done) state_d = mode_i ? S_MAG1 : S_ANG;
      S_ANG:   state_d = S_OUT;
      S_MAG1:  state_d = S_MAG2;
      S_MAG2:  state_d = S_MAG3;
      S_MAG3:  state_d = S_OUT;
      S_OUT:   if (!ov_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    cnt_d  = cnt_q;
    act_d  = act_q;
    neg_d  = neg_q;
    last_d = last_q;
    rx_d   = rx_q;
    ry_d   = ry_q;
    rz_d   = rz_q;
    px_d   = px_q;
    py_d   = py_q;
    xsum_d = xsum_q;
    ysum_d = ysum_q;
    vx_d   = vx_q;
    vy_d   = vy_q;
    vz_d   = vz_q;
    a1_d   = a1_q;
    a2_d   = a2_q;
    b1_d   = b1_q;
    b2_d   = b2_q;
    hs_d   = hs_q;
    ls_d   = ls_q;
    res_d  = res_q;
    sat_d  = sat_q;
    ov_d   = (ov_q && out_ready_i) ? 1'b0 : ov_q;
    xs     = signed'(xsum_q);
    ys     = signed'(ysum_q);
    cs     = 18'((rx_q + 34'sd32768) >>> 16);
    sn     = 18'((ry_q + 34'sd32768) >>> 16);
    ang_w  = 40'(vz_q) * 40'sd45 + 40'sd2097152;
    ang_s  = ang_w >>> 22;
    tmag   = (vx_q > 0) ? vx_q[48:0] : '0;
    lo_full = 64'({b2_q, 25'd0}) + 64'(b1_q);
    msum   = 66'(hs_q) + 66'(ls_q) + 66'd268435456;
    mval   = msum[65:29];
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          pop_o  = 1'b1;
          act_d  = item_i.activation;
          neg_d  = item_i.negate;
          last_d = item_i.last;
          rx_d   = GainQ30;
          ry_d   = '0;
          rz_d   = 34'(item_i.angle);
          cnt_d  = '0;
        end
      end
      S_ROT: begin
        if (rz_q >= 0) begin
          rx_d = rx_q - (ry_q >>> cnt_q);
          ry_d = ry_q + (rx_q >>> cnt_q);
          rz_d = rz_q - 34'(atan_v);
        end else begin
          rx_d = rx_q + (ry_q >>> cnt_q);
          ry_d = ry_q - (rx_q >>> cnt_q);
          rz_d = rz_q + 34'(atan_v);
        end
        cnt_d = rot_done ? '0 : cnt_q + 1'b1;
      end
      S_MUL: begin
        px_d = 34'(act_q) * 34'(neg_q ? -cs : cs);
        py_d = 34'(act_q) * 34'(neg_q ? -sn : sn);
      end
      S_ACC: begin
        xsum_d = xsum_q + 48'(px_q);
        ysum_d = ysum_q + 48'(py_q);
      end
      S_VINIT: begin
        if (!ov_q) begin
          xsum_d = '0;
          ysum_d = '0;
          sat_d  = 1'b0;
          cnt_d  = '0;
          if (xs == '0 && ys == '0) begin
            res_d = '0;
          end else if (!mode_i && ys == '0) begin
            res_d = (xs > 0) ? 32'sd0 : 32'(AngleMax);
          end
          if (xs < 0) begin
            vx_d = -51'(xs);
            vy_d = -51'(ys);
            vz_d = (ys >= 0) ? TurnHalfW : -TurnHalfW;
          end else begin
            vx_d = 51'(xs);
            vy_d = 51'(ys);
            vz_d = '0;
          end
        end
      end
      S_VEC: begin
        if (vy_q >= 0) begin
          vx_d = vx_q + (vy_q >>> cnt_q);
          vy_d = vy_q - (vx_q >>> cnt_q);
          vz_d = vz_q + 34'(atan_v);
        end else begin
          vx_d = vx_q - (vy_q >>> cnt_q);
          vy_d = vy_q + (vx_q >>> cnt_q);
          vz_d = vz_q - 34'(atan_v);
        end
        cnt_d = rot_done ? '0 : cnt_q + 1'b1;
      end
      S_ANG: begin
        if (ang_s > AngleMax) res_d = 32'(AngleMax);
        else if (ang_s < -AngleMax) res_d = 32'(-AngleMax);
        else res_d = 32'(ang_s);
      end
      S_MAG1: begin
        a1_d = 40'(tmag[24:0]) * 40'(GainHi);
        a2_d = 39'(tmag[48:25]) * 39'(GainHi);
        b1_d = 40'(tmag[24:0]) * 40'(GainLo);
        b2_d = 39'(tmag[48:25]) * 39'(GainLo);
      end
      S_MAG2: begin
        hs_d = 65'({a2_q, 25'd0}) + 65'(a1_q);
        ls_d = 50'(lo_full >> 15);
      end
      S_MAG3: begin
        if (mval > MagMax) begin
          res_d = 32'h7FFF_FFFF;
          sat_d = 1'b1;
        end else begin
          res_d = 32'(mval);
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) ov_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      xsum_q  <= '0;
      ysum_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      xsum_q  <= xsum_d;
      ysum_q  <= ysum_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    neg_q  <= neg_d;
    last_q <= last_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    rz_q   <= rz_d;
    px_q   <= px_d;
    py_q   <= py_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    vz_q   <= vz_d;
    a1_q   <= a1_d;
    a2_q   <= a2_d;
    b1_q   <= b1_d;
    b2_q   <= b2_d;
    hs_q   <= hs_d;
    ls_q   <= ls_d;
    if (state_q != S_OUT) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end else if (!ov_q || out_ready_i) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

endmodule

// ----- sv/population_vector_average.sv -----
`timescale 1ns / 1ps
// Sequencing: each item passes the intake register and the queue, then the
// sequencer steps S_IDLE, S_ROT, S_MUL and S_ACC. A last item then waits in S_VINIT
// until the previous result leaves, goes through S_VEC and S_ANG (angle mode) or
// S_MAG1 to S_MAG3 (magnitude mode) unless the sum is trivial, and ends in S_OUT.
// Items are taken one at a time; intake and a four-entry queue absorb short bursts.
// Reset: asynchronous, active low; clears sums, mode, queue and output valid.
// ----------------------------------------------------------------------------
// population_vector_average: top level
// Population vector average of (activation, orientation) pairs with CORDIC
// angle or magnitude result.
// ----------------------------------------------------------------------------
module population_vector_average
  import pva_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // activation[15:0], orientation[31:16]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // result_value[31:0]
  output logic        m_axis_tuser_o,   // saturated[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic  mode_q, mode_d;
  logic  push, push_ready, pop, pop_valid;
  item_t front_item, queue_item;

  assign cfg_ready_o = 1'b1;
  assign mode_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  pva_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid_i),
    .ready_o       (s_axis_tready_o),
    .activation_i  (s_axis_tdata_i[15:0]),
    .orientation_i (s_axis_tdata_i[31:16]),
    .last_i        (s_axis_tlast_i),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .item_o        (front_item)
  );

  pva_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .item_i       (front_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .item_o       (queue_item)
  );

  pva_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .item_i      (queue_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (m_axis_tdata_o),
    .sat_o       (m_axis_tuser_o)
  );

`ifndef SYNTHESIS
  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 32'h7FFF_FFFF)
    else $error("saturated result not clipped");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !mode_q |->
      !m_axis_tuser_o && ($signed(m_axis_tdata_o) <= 32'sd23040) &&
      ($signed(m_axis_tdata_o) >= -32'sd23040))
    else $error("angle result out of range");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("queue read while empty");
`endif

endmodule

// ----- test/population_vector_average_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// population_vector_average_test: self-checking testbench
// Streams runs of (activation, orientation) pairs into the block, predicts the
// angle or magnitude of each run's summed vector with a bit-exact CORDIC model,
// and compares every result, with random gaps and stalls on both streams and
// mode changes between phases.
// ----------------------------------------------------------------------------
module population_vector_average_test;
  import pva_pkg::*;

  localparam int        Stages   = 16;
  localparam longint    Gain     = 64'sd652032874;
  localparam longint    HalfTurn = 64'sd2147483648;
  localparam longint    QtrTurn  = 64'sd1073741824;
  localparam longint    AngLimit = 64'sd23040;
  localparam bit        ModeAngle = 1'b0;
  localparam bit        ModeMag   = 1'b1;

  typedef struct {
    logic [15:0] act;
    logic [15:0] orient;
    logic        last;
    logic        hold;
  } link_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } pop_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  link_t       link_q[$];
  pop_result_t vector_q[$];
  logic [47:0] x_acc = '0;
  logic [47:0] y_acc = '0;
  bit          mode = ModeAngle;
  bit          no_gaps = 1'b0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          errors = 0;
  int          links_sent = 0;
  int          runs_checked = 0;

  population_vector_average #(.CORDIC_STAGES(Stages)) u_top (.*);

  always #6 clk_i = ~clk_i;

  function automatic void sin_cos(input logic [15:0] orient, output longint c,
                                  output longint s);
    longint unsigned o;
    longint z, x, y, nx, ny;
    bit neg;
    o = orient;
    neg = 1'b0;
    x = Gain;
    y = 0;
    if (o >= 46080) o -= 46080;
    z = longint'(((o << 32) + 64'd23040) / 64'd46080);
    if (z >= HalfTurn) z -= 2 * HalfTurn;
    if (z > QtrTurn) begin
      z -= HalfTurn;
      neg = 1'b1;
    end else if (z < -QtrTurn) begin
      z += HalfTurn;
      neg = 1'b1;
    end
    for (int i = 0; i < Stages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(atan_lut(5'(i)));
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(atan_lut(5'(i)));
      end
      x = nx;
      y = ny;
    end
    x = (x + 32768) >>> 16;
    y = (y + 32768) >>> 16;
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic pop_result_t vector_result(input longint xs, input longint ys,
                                                input bit m);
    pop_result_t r;
    longint x, y, z, nx, ny, v;
    longint unsigned t, mg;
    r.sat = 1'b0;
    x = xs;
    y = ys;
    z = 0;
    if (xs == 0 && ys == 0) begin
      v = 0;
    end else if (m == ModeAngle && ys == 0) begin
      v = (xs > 0) ? 0 : AngLimit;
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? HalfTurn : -HalfTurn;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < Stages; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z += longint'(atan_lut(5'(i)));
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z -= longint'(atan_lut(5'(i)));
        end
        x = nx;
        y = ny;
      end
      if (m == ModeAngle) begin
        v = (z * 45 + 64'sd2097152) >>> 22;
        if (v > AngLimit) v = AngLimit;
        if (v < -AngLimit) v = -AngLimit;
      end else begin
        t = (x > 0) ? longint'(x) : 0;
        mg = (t * 64'd19898 + ((t * 64'd15210) >> 15) + (64'd1 << 28)) >> 29;
        if (mg > 64'h7FFF_FFFF) begin
          mg = 64'h7FFF_FFFF;
          r.sat = 1'b1;
        end
        v = longint'(mg);
      end
    end
    r.value = v[31:0];
    return r;
  endfunction

  function automatic void add_link(input logic [15:0] act, input logic [15:0] orient,
                                   input logic last);
    longint c, s, a, px, py;
    sin_cos(orient, c, s);
    a = longint'($signed(act));
    px = a * c;
    py = a * s;
    x_acc = x_acc + px[47:0];
    y_acc = y_acc + py[47:0];
    if (last) begin
      vector_q = {vector_q, vector_result({{16{x_acc[47]}}, x_acc},
                                          {{16{y_acc[47]}}, y_acc}, mode)};
      x_acc = '0;
      y_acc = '0;
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit busy;
    link_t l;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      busy = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        add_link(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16], s_axis_tlast_i);
        links_sent++;
        busy = 1'b0;
        send_gap = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (link_q.size() > 0 && (!link_q[0].hold || vector_q.size() == 0)) begin
          l = link_q.pop_front();
          s_axis_tdata_i <= {l.orient, l.act};
          s_axis_tlast_i <= l.last;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    pop_result_t e;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (vector_q.size() == 0) begin
          $error("unexpected result value=%0d sat=%0d", $signed(m_axis_tdata_o),
                 m_axis_tuser_o);
          errors++;
        end else begin
          e = vector_q.pop_front();
          runs_checked++;
          if (m_axis_tdata_o !== e.value) begin
            $error("result_value expected %0d actual %0d", $signed(e.value),
                   $signed(m_axis_tdata_o));
            errors++;
          end
          if (m_axis_tuser_o !== e.sat) begin
            $error("saturated expected %0d actual %0d", e.sat, m_axis_tuser_o);
            errors++;
          end
        end
        recv_stall = no_gaps ? 0 : $urandom_range(0, 7);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_axis_tready_i <= (recv_stall == 0);
    end
  end

  task automatic push_link(input logic [15:0] act, input logic [15:0] orient,
                           input logic last, input logic hold = 1'b0);
    link_t l;
    l.act = act;
    l.orient = orient;
    l.last = last;
    l.hold = hold;
    link_q = {link_q, l};
  endtask

  task automatic drain();
    while (link_q.size() > 0 || s_axis_tvalid_i || vector_q.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    drain();
    cfg_data_i <= m;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mode = m;
  endtask

  task automatic directed_set();
    push_link(16'sd0, 16'd0, 1'b1);
    push_link(16'h7FFF, 16'd0, 1'b1);
    push_link(16'h8000, 16'd0, 1'b1);
    push_link(16'h0100, 16'd11520, 1'b1);
    push_link(16'h0100, 16'd23040, 1'b1);
    push_link(16'h8000, 16'd34560, 1'b0);
    push_link(16'h7FFF, 16'd46079, 1'b1);
    push_link(16'h0100, 16'd46080, 1'b0);
    push_link(16'h0100, 16'd65535, 1'b1);
    push_link(16'h0100, 16'd0, 1'b0);
    push_link(16'hFF00, 16'd0, 1'b1);
    push_link(16'hFFFF, 16'd5760, 1'b0);
    push_link(16'h5555, 16'd17280, 1'b0);
    push_link(16'hAAAA, 16'd40320, 1'b1);
  endtask

  task automatic random_runs(input int n_links);
    int len;
    int sent;
    sent = 0;
    while (sent < n_links) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        push_link(16'($urandom), ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, 46079)), i == len - 1,
                  i == 0 && $urandom_range(0, 15) == 0);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_set();
    write_mode(ModeMag);
    directed_set();
    write_mode(ModeAngle);
    for (int i = 0; i < 300; i++) push_link(16'h7FFF, 16'd0, i == 299);
    for (int p = 0; p < 6; p++) begin
      no_gaps = (p == 2);
      random_runs(100);
      write_mode(p[0] ? ModeAngle : ModeMag);
    end
    no_gaps = 1'b0;
    random_runs(50);
    drain();
    $display("%0d links sent in %0d checked runs, both result modes, with gaps and stalls",
             links_sent, runs_checked);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pva_pkg.sv
sv/pva_front.sv
sv/pva_fifo.sv
sv/pva_back.sv
sv/population_vector_average.sv
test/population_vector_average_test.sv
